>>> rtl/core/ese_pkg.sv
// shared types, codes and constants of the escape sequence expander
package ese_pkg;

    // input command codes
    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_SEP   = 2'd1,
        CMD_FINAL = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // parser modes, one-hot
    typedef enum logic [5:0] {
        MODE_NORMAL = 6'b000001,
        MODE_ESCAPE = 6'b000010,
        MODE_OCTAL  = 6'b000100,
        MODE_DROP   = 6'b001000,
        MODE_DONE   = 6'b010000,
        MODE_ERROR  = 6'b100000
    } mode_t;

    // character constants
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_C         = 8'h63;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [7:0] OCTAL_LIMIT  = 8'd32;

    // control codes produced by escapes
    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_HT  = 8'd9;
    localparam logic [7:0] CODE_VT  = 8'd11;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // input word
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] char_byte;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       error_flag;
        logic       last;
    } out_word_t;

    // one or two results caused by one input word
    typedef struct packed {
        logic       pair;
        logic [7:0] byte0;
        logic       err0;
        logic [7:0] byte1;
    } job_t;

    // queue side-band toward the back end
    typedef struct packed {
        logic not_empty;
        job_t head;
    } queue_out_t;

    // separator byte for an argument end
    function automatic logic [7:0] sep_byte(input cmd_t cmd);
        sep_byte = (cmd == CMD_SEP) ? CH_SPACE : CH_NEWLINE;
    endfunction

endpackage

>>> rtl/core/ese_front.sv
// front end: accepts words, runs the escape parser and issues result jobs
module ese_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  ese_pkg::in_word_t item,
    output logic            enq,
    output ese_pkg::job_t   job
);
    import ese_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] octal_reg, octal_next;
    logic       is_digit;

    assign is_digit = (item.char_byte >= CH_ZERO) && (item.char_byte <= CH_SEVEN);

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            octal_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            octal_reg <= octal_next;
        end
    end

    // mode decode and job build
    always_comb
    begin
        mode_next  = mode_reg;
        octal_next = octal_reg;
        enq        = 1'b0;
        job.pair   = 1'b0;
        job.byte0  = '0;
        job.err0   = 1'b0;
        job.byte1  = sep_byte(item.cmd);
        if (accept && item.cmd != CMD_NONE)
        begin
            unique case (mode_reg)
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    if (item.cmd != CMD_CHAR)
                    begin
                        // trailing backslash then separator
                        enq       = 1'b1;
                        job.pair  = 1'b1;
                        job.byte0 = CH_BACKSLASH;
                        if (item.cmd == CMD_FINAL)
                            octal_next = '0;
                    end
                    else
                    begin
                        enq = 1'b1;
                        case (item.char_byte)
                            CH_A:         job.byte0 = CODE_BEL;
                            CH_B:         job.byte0 = CODE_BS;
                            CH_F:         job.byte0 = CODE_FF;
                            CH_N:         job.byte0 = CODE_LF;
                            CH_R:         job.byte0 = CODE_CR;
                            CH_T:         job.byte0 = CODE_HT;
                            CH_V:         job.byte0 = CODE_VT;
                            CH_BACKSLASH: job.byte0 = CH_BACKSLASH;
                            CH_C:
                            begin
                                enq       = 1'b0;
                                mode_next = MODE_DROP;
                            end
                            CH_ZERO:
                            begin
                                enq        = 1'b0;
                                mode_next  = MODE_OCTAL;
                                octal_next = '0;
                            end
                            default:
                            begin
                                job.err0  = 1'b1;
                                mode_next = MODE_ERROR;
                            end
                        endcase
                    end
                end
                MODE_OCTAL:
                begin
                    if (item.cmd != CMD_CHAR)
                    begin
                        // run value then separator
                        enq       = 1'b1;
                        job.pair  = 1'b1;
                        job.byte0 = octal_reg;
                        mode_next = MODE_NORMAL;
                        if (item.cmd == CMD_FINAL)
                            octal_next = '0;
                    end
                    else if (is_digit && octal_reg < OCTAL_LIMIT)
                    begin
                        octal_next = {octal_reg[4:0], item.char_byte[2:0]};
                    end
                    else
                    begin
                        // run ends, byte handled as normal text
                        enq       = 1'b1;
                        job.byte0 = octal_reg;
                        if (item.char_byte == CH_BACKSLASH)
                        begin
                            mode_next = MODE_ESCAPE;
                        end
                        else
                        begin
                            mode_next = MODE_NORMAL;
                            job.pair  = 1'b1;
                            job.byte1 = item.char_byte;
                        end
                    end
                end
                MODE_DROP:
                begin
                    if (item.cmd == CMD_SEP)
                    begin
                        enq       = 1'b1;
                        job.byte0 = CH_SPACE;
                        mode_next = MODE_DONE;
                    end
                    else if (item.cmd == CMD_FINAL)
                    begin
                        mode_next  = MODE_NORMAL;
                        octal_next = '0;
                    end
                end
                MODE_DONE, MODE_ERROR:
                begin
                    if (item.cmd == CMD_FINAL)
                    begin
                        mode_next  = MODE_NORMAL;
                        octal_next = '0;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    if (item.cmd == CMD_CHAR)
                    begin
                        if (item.char_byte == CH_BACKSLASH)
                        begin
                            mode_next = MODE_ESCAPE;
                        end
                        else
                        begin
                            enq       = 1'b1;
                            job.byte0 = item.char_byte;
                        end
                    end
                    else
                    begin
                        enq       = 1'b1;
                        job.byte0 = sep_byte(item.cmd);
                        if (item.cmd == CMD_FINAL)
                            octal_next = '0;
                    end
                end
            endcase
        end
    end

endmodule

>>> rtl/core/ese_queue.sv
// job queue between front end and back end
module ese_queue #(
    parameter int Depth = ese_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enq,
    input  ese_pkg::job_t       job,
    input  logic                deq,
    output logic                full,
    output ese_pkg::queue_out_t qout
);
    import ese_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    job_t            slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full           = (count_reg == FullCnt);
    assign qout.not_empty = (count_reg != '0);
    assign qout.head      = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (deq)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (enq && !deq)
            count_next = count_reg + 1'b1;
        else if (deq && !enq)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (enq)
            slot_reg[wr_ptr_reg] <= job;
    end

    // checks
    a_no_enq_full: assert property (@(posedge clk) disable iff (!rst_n)
        enq |-> !full)
        else $error("job written into a full queue");
    a_no_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> qout.not_empty)
        else $error("job taken from an empty queue");

endmodule

>>> rtl/core/ese_back.sv
// back end: splits jobs into result words behind an output register
module ese_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ese_pkg::queue_out_t qout,
    output logic                deq,
    input  logic                pop,
    output logic                empty,
    output ese_pkg::out_word_t  result
);
    import ese_pkg::*;

    out_word_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    logic       pend_reg, pend_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       load_ok;

    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign load_ok = !out_valid_reg || pop;

    // output slot refill: pending second byte first, then next job
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        deq            = 1'b0;
        if (load_ok)
        begin
            if (pend_reg)
            begin
                out_next.out_byte   = pend_byte_reg;
                out_next.error_flag = 1'b0;
                out_next.last       = 1'b1;
                out_valid_next      = 1'b1;
                pend_next           = 1'b0;
            end
            else if (qout.not_empty)
            begin
                deq                 = 1'b1;
                out_next.out_byte   = qout.head.byte0;
                out_next.error_flag = qout.head.err0;
                out_next.last       = !qout.head.pair;
                out_valid_next      = 1'b1;
                pend_next           = qout.head.pair;
                pend_byte_next      = qout.head.byte1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        pend_byte_reg <= pend_byte_next;
    end

    // checks
    a_pend_has_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (out_valid_reg && !out_reg.last))
        else $error("second byte pending without its first word shown");
    a_no_deq_with_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !deq)
        else $error("job taken while a second byte is pending");

endmodule

>>> rtl/core/escape_sequence_expander.sv
// top level of the escape sequence expander
//
//   channel   handshake          word         direction
//   input     push / full        item         in: cmd, char_byte
//   result    pop / empty        result       out: out_byte, error_flag, last
//
// an input word is taken every cycle while the job queue has room; the
// front end decides its results in the same cycle and writes at most one job.
// the back end shows one result word per cycle while results are popped, so
// a word that gives two results keeps its second byte in a pending register.
// reset clears parser mode, queue pointers and the output valid flag.
// the two sides stall independently; full rises only when the queue fills.
module escape_sequence_expander #(
    parameter int QueueDepth = ese_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ese_pkg::in_word_t  item,
    output logic               empty,
    input  logic               pop,
    output ese_pkg::out_word_t result
);
    import ese_pkg::*;

    logic       accept;
    logic       enq;
    logic       deq;
    job_t       job;
    queue_out_t qout;

    assign accept = push && !full;

    // parser front end
    ese_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .enq    (enq),
        .job    (job)
    );

    // job queue
    ese_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .enq   (enq),
        .job   (job),
        .deq   (deq),
        .full  (full),
        .qout  (qout)
    );

    // result back end
    ese_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qout   (qout),
        .deq    (deq),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

>>> tb/escape_sequence_expander_tb.sv
// self-checking testbench of the escape sequence expander
module escape_sequence_expander_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ese_pkg::*;

    localparam int RANDOM_WORDS = 1350;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      full;
    in_word_t  item  = '0;
    logic      empty;
    logic      pop   = 1'b0;
    out_word_t result;

    escape_sequence_expander uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // words waiting to be sent, with a flag to wait for an empty pipe first
    in_word_t  send_q[$];
    bit        hold_q[$];
    bit        hold_next = 1'b0;

    // expanded bytes still owed by the block
    out_word_t expected_q[$];

    // own copy of the parser state
    mode_t      parse_state = MODE_NORMAL;
    logic [7:0] octal_acc   = 8'd0;

    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  finishing   = 1'b0;
    int  burst_left  = 1;
    int  gap_left    = 0;
    int  stall_style = 0;
    int  stall_timer = 0;

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ---------------------------------------------------------------
    // expansion predictor
    // ---------------------------------------------------------------

    task automatic add_result(inout int n, inout out_word_t r0, inout out_word_t r1,
                              input logic [7:0] b, input logic e);
        out_word_t r;
        r = '{out_byte: b, error_flag: e, last: 1'b0};
        if (n == 0)
            r0 = r;
        else
            r1 = r;
        n++;
    endtask

    // separator or final newline
    task automatic end_argument(input cmd_t c, inout int n, inout out_word_t r0,
                                inout out_word_t r1);
        if (c == CMD_SEP)
            add_result(n, r0, r1, CH_SPACE, 1'b0);
        else
        begin
            add_result(n, r0, r1, CH_NEWLINE, 1'b0);
            octal_acc = 8'd0;
        end
        parse_state = MODE_NORMAL;
    endtask

    task automatic plain_byte(input logic [7:0] b, inout int n, inout out_word_t r0,
                              inout out_word_t r1);
        if (b == CH_BACKSLASH)
            parse_state = MODE_ESCAPE;
        else
            add_result(n, r0, r1, b, 1'b0);
    endtask

    task automatic expand_word(input in_word_t w);
        out_word_t r0;
        out_word_t r1;
        int        n;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (w.cmd != CMD_NONE)
        begin
            case (parse_state)
                MODE_ESCAPE:
                begin
                    if (w.cmd != CMD_CHAR)
                    begin
                        // trailing backslash
                        add_result(n, r0, r1, CH_BACKSLASH, 1'b0);
                        end_argument(w.cmd, n, r0, r1);
                    end
                    else
                    begin
                        parse_state = MODE_NORMAL;
                        case (w.char_byte)
                            CH_A:         add_result(n, r0, r1, CODE_BEL, 1'b0);
                            CH_B:         add_result(n, r0, r1, CODE_BS, 1'b0);
                            CH_F:         add_result(n, r0, r1, CODE_FF, 1'b0);
                            CH_N:         add_result(n, r0, r1, CODE_LF, 1'b0);
                            CH_R:         add_result(n, r0, r1, CODE_CR, 1'b0);
                            CH_T:         add_result(n, r0, r1, CODE_HT, 1'b0);
                            CH_V:         add_result(n, r0, r1, CODE_VT, 1'b0);
                            CH_BACKSLASH: add_result(n, r0, r1, CH_BACKSLASH, 1'b0);
                            CH_C:         parse_state = MODE_DROP;
                            CH_ZERO:
                            begin
                                parse_state = MODE_OCTAL;
                                octal_acc   = 8'd0;
                            end
                            default:
                            begin
                                add_result(n, r0, r1, 8'd0, 1'b1);
                                parse_state = MODE_ERROR;
                            end
                        endcase
                    end
                end
                MODE_OCTAL:
                begin
                    if (w.cmd != CMD_CHAR)
                    begin
                        add_result(n, r0, r1, octal_acc, 1'b0);
                        end_argument(w.cmd, n, r0, r1);
                    end
                    else if (w.char_byte >= CH_ZERO && w.char_byte <= CH_SEVEN &&
                             octal_acc < OCTAL_LIMIT)
                        octal_acc = (octal_acc << 3) | (w.char_byte - CH_ZERO);
                    else
                    begin
                        // run ends, the byte is then plain text
                        add_result(n, r0, r1, octal_acc, 1'b0);
                        parse_state = MODE_NORMAL;
                        plain_byte(w.char_byte, n, r0, r1);
                    end
                end
                MODE_DROP:
                begin
                    if (w.cmd == CMD_SEP)
                    begin
                        add_result(n, r0, r1, CH_SPACE, 1'b0);
                        parse_state = MODE_DONE;
                    end
                    else if (w.cmd == CMD_FINAL)
                    begin
                        parse_state = MODE_NORMAL;
                        octal_acc   = 8'd0;
                    end
                end
                MODE_DONE, MODE_ERROR:
                begin
                    if (w.cmd == CMD_FINAL)
                    begin
                        parse_state = MODE_NORMAL;
                        octal_acc   = 8'd0;
                    end
                end
                default:
                begin
                    parse_state = MODE_NORMAL;
                    if (w.cmd == CMD_CHAR)
                        plain_byte(w.char_byte, n, r0, r1);
                    else
                        end_argument(w.cmd, n, r0, r1);
                end
            endcase
        end
        // mark the final byte of this word
        if (n == 1)
            r0.last = 1'b1;
        if (n == 2)
            r1.last = 1'b1;
        if (n > 0)
            expected_q.push_back(r0);
        if (n > 1)
            expected_q.push_back(r1);
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_word(input cmd_t c, input logic [7:0] b);
        send_q.push_back('{cmd: c, char_byte: b});
        hold_q.push_back(hold_next);
        hold_next = 1'b0;
    endtask

    task automatic queue_escape(input logic [7:0] b);
        queue_word(CMD_CHAR, CH_BACKSLASH);
        queue_word(CMD_CHAR, b);
    endtask

    function automatic logic [7:0] pick_escape_letter();
        case ($urandom_range(0, 7))
            0:       return CH_A;
            1:       return CH_B;
            2:       return CH_F;
            3:       return CH_N;
            4:       return CH_R;
            5:       return CH_T;
            6:       return CH_V;
            default: return CH_BACKSLASH;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // driver: bursts of words with random gaps
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                expand_word(item);
                void'(send_q.pop_front());
                void'(hold_q.pop_front());
            end
            if (push && full)
            begin
                // word not taken yet, keep it on the port
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (send_q.size() == 0 || (hold_q[0] && expected_q.size() != 0))
                push <= 1'b0;
            else
            begin
                push <= 1'b1;
                item <= send_q[0];
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks each result word and stalls on its own pattern
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        logic      pop_next;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected word: byte %02h err %0b last %0b",
                                 $realtime, result.out_byte, result.error_flag, result.last);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.out_byte !== want.out_byte ||
                        result.error_flag !== want.error_flag ||
                        result.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("[%0t] mismatch: expected byte %02h err %0b last %0b",
                                     $realtime, want.out_byte, want.error_flag, want.last);
                            $display("    got byte %02h err %0b last %0b",
                                     result.out_byte, result.error_flag, result.last);
                        end
                    end
                end
            end
            // switch the stall style now and then
            if (stall_timer == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_timer = $urandom_range(50, 300);
            end
            else
                stall_timer--;
            case (stall_style)
                0:       pop_next = 1'b1;
                1:       pop_next = 1'($urandom_range(0, 1));
                2:       pop_next = (cycle_count % 3 == 0);
                default: pop_next = ($urandom_range(0, 9) == 0);
            endcase
            pop <= pop_next | finishing;
        end
    end

    // timeout
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        int       start_size;
        int       n_args;
        int       n_segs;
        int       n_digits;
        int       pick;
        bit       cut;
        logic [7:0] b;

        // plain bytes at the extremes and an unused command
        queue_word(CMD_CHAR, 8'h00);
        queue_word(CMD_CHAR, 8'hFF);
        queue_word(CMD_NONE, 8'hA5);
        // every escape that maps to one byte
        queue_escape(CH_A);
        queue_escape(CH_B);
        queue_escape(CH_F);
        queue_escape(CH_N);
        queue_escape(CH_R);
        queue_escape(CH_T);
        queue_escape(CH_V);
        queue_escape(CH_BACKSLASH);
        // octal run reaching the limit, then one more digit as plain text
        queue_escape(CH_ZERO);
        queue_word(CMD_CHAR, 8'h33);
        queue_word(CMD_CHAR, CH_SEVEN);
        queue_word(CMD_CHAR, CH_SEVEN);
        queue_word(CMD_CHAR, CH_SEVEN);
        queue_word(CMD_SEP, 8'h00);
        // octal run cut by the argument end
        queue_escape(CH_ZERO);
        queue_word(CMD_CHAR, 8'h31);
        queue_word(CMD_FINAL, 8'h00);
        // stop after backslash-c
        queue_escape(CH_C);
        queue_word(CMD_SEP, 8'h00);
        queue_word(CMD_CHAR, 8'h7A);
        queue_word(CMD_FINAL, 8'h00);
        // unknown escape of byte zero, then ignored until the final end
        queue_escape(8'h00);
        queue_word(CMD_CHAR, 8'h41);
        queue_word(CMD_FINAL, 8'h00);
        // trailing backslash before a separator and before the final end
        queue_word(CMD_CHAR, CH_BACKSLASH);
        queue_word(CMD_SEP, 8'h00);
        queue_word(CMD_CHAR, CH_BACKSLASH);
        queue_word(CMD_FINAL, 8'h00);

        // random command lines, the first one after a full drain
        start_size = send_q.size();
        hold_next  = 1'b1;
        while (send_q.size() - start_size < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 19) == 0)
                hold_next = 1'b1;
            if ($urandom_range(0, 19) == 0)
            begin
                // noise: a few words of any kind
                repeat ($urandom_range(1, 4))
                    queue_word(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            n_args = $urandom_range(1, 5);
            for (int a = 0; a < n_args; a++)
            begin
                n_segs = $urandom_range(0, 6);
                cut    = 1'b0;
                for (int s = 0; s < n_segs && !cut; s++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)
                        queue_word(CMD_CHAR, 8'($urandom_range(0, 255)));
                    else if (pick < 65)
                        queue_escape(pick_escape_letter());
                    else if (pick < 80)
                    begin
                        queue_escape(CH_ZERO);
                        n_digits = $urandom_range(0, 4);
                        repeat (n_digits)
                        begin
                            b = CH_ZERO + 8'($urandom_range(0, 7));
                            queue_word(CMD_CHAR, b);
                        end
                    end
                    else if (pick < 84)
                        queue_escape(CH_C);
                    else if (pick < 87)
                        queue_escape(8'($urandom_range(0, 255)));
                    else if (pick < 92)
                        queue_word(CMD_NONE, 8'($urandom_range(0, 255)));
                    else
                    begin
                        // trailing backslash ends the argument
                        queue_word(CMD_CHAR, CH_BACKSLASH);
                        cut = 1'b1;
                    end
                end
                queue_word((a == n_args - 1) ? CMD_FINAL : CMD_SEP, 8'($urandom_range(0, 255)));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (send_q.size() != 0)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        finishing = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ese_pkg.sv
rtl/core/ese_front.sv
rtl/core/ese_queue.sv
rtl/core/ese_back.sv
rtl/core/escape_sequence_expander.sv
tb/escape_sequence_expander_tb.sv
